// File: hw/rtl/servo_sync_write_packet_framer_core_assert.svh
// Assertion macros shared by the sync-write framer RTL.
`ifndef SERVO_SYNC_WRITE_PACKET_FRAMER_CORE_ASSERT_SVH
`define SERVO_SYNC_WRITE_PACKET_FRAMER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SVSF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SVSF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SVSF_ASSERT(lbl, prop, msg)
`define SVSF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/svsf_pkg.sv
// Package: constants, codes and controller/datapath types of the sync-write framer.
`timescale 1ns / 1ps
`default_nettype none
package svsf_pkg;
   localparam int MAX_SERVOS_DEFAULT = 16;
   localparam int CNT_W = 5;
   localparam int ADDR_W = 3;

   localparam logic [7:0] HDR_BYTE = 8'hFF;
   localparam logic [7:0] BCAST_ID = 8'hFE;
   localparam logic [7:0] SYNC_INSTR = 8'h83;
   localparam logic [7:0] WORD_LEN = 8'h02;
   localparam logic [7:0] LEN_BASE = 8'h04;
   localparam logic [7:0] REG_RESET = 8'd42;
   localparam logic [7:0] REG_INVALID = 8'hFF;

   localparam logic [ADDR_W-1:0] ADDR_TARGET_REG = 3'd0;

   localparam logic [2:0] STAT_OK = 3'd0;
   localparam logic [2:0] STAT_BAD_COUNT = 3'd1;
   localparam logic [2:0] STAT_BAD_REG = 3'd2;
   localparam logic [2:0] STAT_BAD_ID = 3'd3;
   localparam logic [2:0] STAT_DUP_ID = 3'd4;

   localparam logic [1:0] IDERR_NONE = 2'd0;
   localparam logic [1:0] IDERR_BAD = 2'd1;
   localparam logic [1:0] IDERR_DUP = 2'd2;

   localparam logic [3:0] SEL_HDR = 4'd0;
   localparam logic [3:0] SEL_BCAST = 4'd1;
   localparam logic [3:0] SEL_LEN = 4'd2;
   localparam logic [3:0] SEL_INSTR = 4'd3;
   localparam logic [3:0] SEL_REG = 4'd4;
   localparam logic [3:0] SEL_WLEN = 4'd5;
   localparam logic [3:0] SEL_ID = 4'd6;
   localparam logic [3:0] SEL_PLO = 4'd7;
   localparam logic [3:0] SEL_PHI = 4'd8;
   localparam logic [3:0] SEL_SUM = 4'd9;
   localparam logic [3:0] SEL_ERR = 4'd10;

   typedef struct packed {
      logic             accept;
      logic             emit;
      logic [3:0]       sel;
      logic             clear;
      logic [CNT_W-1:0] rd_idx;
   } cmd_type;

   typedef struct packed {
      logic [2:0]       code;
      logic [CNT_W-1:0] count;
      logic             out_free;
   } sts_type;
endpackage
`default_nettype wire

// File: hw/rtl/svsf_req_if.sv
// Entry channel: bus id, position and last-entry flag with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface svsf_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  bus_id;
   logic [15:0] position;
   logic        last_entry;

   modport source (output valid, output bus_id, output position, output last_entry,
                   input ready);
   modport sink (input valid, input bus_id, input position, input last_entry,
                 output ready);
endinterface
`default_nettype wire

// File: hw/rtl/svsf_rsp_if.sv
// Result channel: frame byte, status and last-byte flag with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface svsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [2:0] status;
   logic       last_byte;

   modport source (output valid, output out_byte, output status, output last_byte,
                   input ready);
   modport sink (input valid, input out_byte, input status, input last_byte,
                 output ready);
endinterface
`default_nettype wire

// File: hw/rtl/servo_sync_write_packet_framer_core.sv
// Top level: sync-write frame builder with APB register port.
`timescale 1ns / 1ps
`default_nettype none
// Collects (servo id, position) entries, one per cycle while idle, and on the entry
// flagged last emits the broadcast sync-write frame FF FF FE len 83 reg 02
// {id lo hi}xN cksum, one byte per transaction, or a single error transaction
// with out_byte 0 and last_byte set. Entries are refused while a set is checked
// or its frame is sent; the set check state lies between the last entry and the
// first byte, and bytes leave through a single output byte register. A new set
// may start while the final byte still waits on rsp_chan. No clearing pass is
// needed after reset. target_register sits at byte address 0 and resets to 42.
module servo_sync_write_packet_framer_core #(
   parameter int MAX_SERVOS = svsf_pkg::MAX_SERVOS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   svsf_req_if.sink                         req_chan,
   svsf_rsp_if.source                       rsp_chan,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [svsf_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                 pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   logic [7:0]        target_reg_ff;
   svsf_pkg::cmd_type cmd;
   svsf_pkg::sts_type sts;
   logic              csr_hit;

   assign pready = 1'b1;
   assign csr_hit = (paddr == svsf_pkg::ADDR_TARGET_REG);
   assign prdata = csr_hit ? {24'h000000, target_reg_ff} : 32'h00000000;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_reg_ff <= svsf_pkg::REG_RESET;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         target_reg_ff <= pwdata[7:0];
      end
   end

   svsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_entry),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   svsf_dp #(
      .MAX_SERVOS (MAX_SERVOS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_bus_id    (req_chan.bus_id),
      .req_position  (req_chan.position),
      .target_reg    (target_reg_ff),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_out_byte  (rsp_chan.out_byte),
      .rsp_status    (rsp_chan.status),
      .rsp_last_byte (rsp_chan.last_byte)
   );
endmodule
`default_nettype wire

// File: hw/rtl/svsf_ctrl.sv
// Sequencer: entry acceptance, set check and frame byte ordering.
`timescale 1ns / 1ps
`default_nettype none
`include "servo_sync_write_packet_framer_core_assert.svh"
module svsf_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_last,
   output logic                  req_ready,
   input  wire svsf_pkg::sts_type sts,
   output svsf_pkg::cmd_type     cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CHK = 3'd1;
   localparam logic [2:0] S_ERR = 3'd2;
   localparam logic [2:0] S_HDR = 3'd3;
   localparam logic [2:0] S_BODY = 3'd4;
   localparam logic [2:0] S_SUM = 3'd5;
   localparam int CntW = svsf_pkg::CNT_W;

   logic [2:0]      state_ff, state_in;
   logic [2:0]      hcnt_ff, hcnt_in;
   logic [1:0]      fld_ff, fld_in;
   logic [CntW-1:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      hcnt_in = hcnt_ff;
      fld_in = fld_ff;
      idx_in = idx_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && req_last) state_in = S_CHK;
         end
         S_CHK: begin
            if (sts.code != svsf_pkg::STAT_OK) begin
               state_in = S_ERR;
            end else begin
               state_in = S_HDR;
               hcnt_in = 3'd0;
               idx_in = '0;
            end
         end
         S_ERR: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel = svsf_pkg::SEL_ERR;
               cmd.clear = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_HDR: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               case (hcnt_ff)
                  3'd0, 3'd1: cmd.sel = svsf_pkg::SEL_HDR;
                  3'd2: cmd.sel = svsf_pkg::SEL_BCAST;
                  3'd3: cmd.sel = svsf_pkg::SEL_LEN;
                  3'd4: cmd.sel = svsf_pkg::SEL_INSTR;
                  3'd5: cmd.sel = svsf_pkg::SEL_REG;
                  default: cmd.sel = svsf_pkg::SEL_WLEN;
               endcase
               if (hcnt_ff == 3'd6) begin
                  state_in = S_BODY;
                  fld_in = 2'd0;
               end else begin
                  hcnt_in = hcnt_ff + 3'd1;
               end
            end
         end
         S_BODY: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               case (fld_ff)
                  2'd0: cmd.sel = svsf_pkg::SEL_ID;
                  2'd1: cmd.sel = svsf_pkg::SEL_PLO;
                  default: cmd.sel = svsf_pkg::SEL_PHI;
               endcase
               if (fld_ff == 2'd2) begin
                  fld_in = 2'd0;
                  if (idx_ff + CntW'(1) == sts.count) begin
                     state_in = S_SUM;
                     idx_in = '0;
                  end else begin
                     idx_in = idx_ff + CntW'(1);
                  end
               end else begin
                  fld_in = fld_ff + 2'd1;
               end
            end
         end
         S_SUM: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel = svsf_pkg::SEL_SUM;
               cmd.clear = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      cmd.rd_idx = idx_in;
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hcnt_ff <= 3'd0;
         fld_ff <= 2'd0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         hcnt_ff <= hcnt_in;
         fld_ff <= fld_in;
         idx_ff <= idx_in;
      end
   end

   `SVSF_ASSERT(a_emit_needs_slot, cmd.emit |-> sts.out_free, "byte issued to a busy output")
   `SVSF_ASSERT(a_chk_exit, (state_ff == S_CHK) |=> (state_ff == S_ERR || state_ff == S_HDR),
                "set check did not branch to error or header")
   `SVSF_ASSERT(a_body_idx, (state_ff == S_BODY) |-> (idx_ff < sts.count),
                "entry index past stored count")
   `SVSF_ASSERT(a_clear_last, cmd.clear |-> (cmd.emit && (cmd.sel == svsf_pkg::SEL_SUM ||
                cmd.sel == svsf_pkg::SEL_ERR)), "set cleared away from final byte")
endmodule
`default_nettype wire

// File: hw/rtl/svsf_dp.sv
// Datapath: entry stores, id checks, byte mux, checksum and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "servo_sync_write_packet_framer_core_assert.svh"
module svsf_dp #(
   parameter int MAX_SERVOS = svsf_pkg::MAX_SERVOS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        req_bus_id,
   input  wire logic [15:0]       req_position,
   input  wire logic [7:0]        target_reg,
   input  wire svsf_pkg::cmd_type cmd,
   output svsf_pkg::sts_type      sts,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_out_byte,
   output logic [2:0]             rsp_status,
   output logic                   rsp_last_byte
);
   localparam int CntW = svsf_pkg::CNT_W;
   localparam int IdxW = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;

   logic [7:0]      id_ff [MAX_SERVOS];
   logic [15:0]     pos_mem [MAX_SERVOS];
   logic [7:0]      rd_id_ff;
   logic [15:0]     rd_pos_ff;

   logic [CntW-1:0] count_ff, count_in;
   logic            ovf_ff, ovf_in;
   logic [1:0]      iderr_ff, iderr_in;
   logic [7:0]      sum_ff, sum_in;
   logic            rsp_valid_ff;
   logic [7:0]      byte_ff;
   logic [2:0]      stat_ff;
   logic            last_ff;

   logic            has_room;
   logic            id_bad;
   logic            id_dup;
   logic [7:0]      len_byte;
   logic [7:0]      byte_sel;
   logic [2:0]      code;

   assign has_room = count_ff < CntW'(MAX_SERVOS);
   assign id_bad = req_bus_id inside {8'h00, [svsf_pkg::BCAST_ID:8'hFF]};
   assign len_byte = svsf_pkg::LEN_BASE + {2'b00, count_ff, 1'b0} + {3'b000, count_ff};

   // while no id fault is pending, every stored id is valid and unique
   always_comb begin
      id_dup = 1'b0;
      for (int i = 0; i < MAX_SERVOS; i++) begin
         if ((CntW'(i) < count_ff) && (id_ff[i] == req_bus_id)) id_dup = 1'b1;
      end
   end

   always_comb begin
      if (ovf_ff) code = svsf_pkg::STAT_BAD_COUNT;
      else if (target_reg == svsf_pkg::REG_INVALID) code = svsf_pkg::STAT_BAD_REG;
      else if (iderr_ff == svsf_pkg::IDERR_BAD) code = svsf_pkg::STAT_BAD_ID;
      else if (iderr_ff == svsf_pkg::IDERR_DUP) code = svsf_pkg::STAT_DUP_ID;
      else code = svsf_pkg::STAT_OK;
   end

   assign sts.code = code;
   assign sts.count = count_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      count_in = count_ff;
      ovf_in = ovf_ff;
      iderr_in = iderr_ff;
      if (cmd.accept) begin
         if (has_room) begin
            count_in = count_ff + CntW'(1);
            if (iderr_ff == svsf_pkg::IDERR_NONE) begin
               if (id_bad) iderr_in = svsf_pkg::IDERR_BAD;
               else if (id_dup) iderr_in = svsf_pkg::IDERR_DUP;
            end
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.clear) begin
         count_in = '0;
         ovf_in = 1'b0;
         iderr_in = svsf_pkg::IDERR_NONE;
      end
   end

   always_comb begin
      case (cmd.sel)
         svsf_pkg::SEL_HDR: byte_sel = svsf_pkg::HDR_BYTE;
         svsf_pkg::SEL_BCAST: byte_sel = svsf_pkg::BCAST_ID;
         svsf_pkg::SEL_LEN: byte_sel = len_byte;
         svsf_pkg::SEL_INSTR: byte_sel = svsf_pkg::SYNC_INSTR;
         svsf_pkg::SEL_REG: byte_sel = target_reg;
         svsf_pkg::SEL_WLEN: byte_sel = svsf_pkg::WORD_LEN;
         svsf_pkg::SEL_ID: byte_sel = rd_id_ff;
         svsf_pkg::SEL_PLO: byte_sel = rd_pos_ff[7:0];
         svsf_pkg::SEL_PHI: byte_sel = rd_pos_ff[15:8];
         svsf_pkg::SEL_SUM: byte_sel = ~sum_ff;
         default: byte_sel = 8'h00;
      endcase
   end

   always_comb begin
      sum_in = sum_ff;
      if (cmd.clear) begin
         sum_in = 8'h00;
      end else if (cmd.emit && !(cmd.sel inside {svsf_pkg::SEL_HDR, svsf_pkg::SEL_SUM,
                                                  svsf_pkg::SEL_ERR})) begin
         sum_in = sum_ff + byte_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && has_room) begin
         id_ff[count_ff[IdxW-1:0]] <= req_bus_id;
         pos_mem[count_ff[IdxW-1:0]] <= req_position;
      end
      rd_id_ff <= id_ff[cmd.rd_idx[IdxW-1:0]];
      rd_pos_ff <= pos_mem[cmd.rd_idx[IdxW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff <= 1'b0;
         iderr_ff <= svsf_pkg::IDERR_NONE;
         sum_ff <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         iderr_ff <= iderr_in;
         sum_ff <= sum_in;
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         byte_ff <= byte_sel;
         stat_ff <= (cmd.sel == svsf_pkg::SEL_ERR) ? code : svsf_pkg::STAT_OK;
         last_ff <= (cmd.sel == svsf_pkg::SEL_ERR) || (cmd.sel == svsf_pkg::SEL_SUM);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_status = stat_ff;
   assign rsp_last_byte = last_ff;

   `SVSF_ASSERT(a_count_max, count_ff <= CntW'(MAX_SERVOS), "entry count beyond capacity")
   `SVSF_ASSERT(a_ovf_full, ovf_ff |-> (count_ff == CntW'(MAX_SERVOS)),
                "overflow flagged with free store entries")
   `SVSF_ASSERT(a_clear_done, cmd.clear |=> (count_ff == '0 && !ovf_ff && iderr_ff == svsf_pkg::IDERR_NONE && sum_ff == 8'h00),
                "set state not cleared after final byte")
   `SVSF_ASSERT(a_err_is_last, (rsp_valid_ff && stat_ff != svsf_pkg::STAT_OK) |-> last_ff,
                "error transaction without last flag")
endmodule
`default_nettype wire

// File: tb/tb_servo_sync_write_packet_framer_core.sv
// Testbench for the sync-write framer: directed and random entry sets checked byte by byte against a predictor.
`timescale 1ns / 1ps
module tb_servo_sync_write_packet_framer_core;
   localparam int MAX_ENTRIES = svsf_pkg::MAX_SERVOS_DEFAULT;
   localparam int RANDOM_ITEMS = 93;
   localparam int LONG_HOLD_CYCLES = 400;

   typedef struct {
      logic [7:0] out_byte;
      logic [2:0] status;
      logic       last_byte;
   } frame_byte_type;

   class sync_frame_scoreboard;
      frame_byte_type pending_bytes[$];
      logic [7:0]  ids[MAX_ENTRIES];
      logic [15:0] positions[MAX_ENTRIES];
      int unsigned entry_count;
      bit          overflow;
      logic [1:0]  first_id_err;
      bit          seen_ids[256];
      logic [7:0]  target_reg;
      int          mismatches;

      function new();
         target_reg = svsf_pkg::REG_RESET;
         mismatches = 0;
         clear_set();
      endfunction

      function void clear_set();
         entry_count = 0;
         overflow = 1'b0;
         first_id_err = svsf_pkg::IDERR_NONE;
         foreach (seen_ids[i]) seen_ids[i] = 1'b0;
      endfunction

      function void push_byte(logic [7:0] b, logic [2:0] st, logic lb);
         frame_byte_type e;
         e.out_byte = b;
         e.status = st;
         e.last_byte = lb;
         pending_bytes.push_back(e);
      endfunction

      // Store one entry; on the closing entry queue the frame or the error result.
      function void note_entry(logic [7:0] id, logic [15:0] pos, logic is_last);
         logic [2:0] st;
         logic [7:0] cksum;
         logic [7:0] body[$];
         if (entry_count < MAX_ENTRIES) begin
            ids[entry_count] = id;
            positions[entry_count] = pos;
            entry_count++;
            if (first_id_err == svsf_pkg::IDERR_NONE) begin
               if (id == 8'h00 || id >= svsf_pkg::BCAST_ID) first_id_err = svsf_pkg::IDERR_BAD;
               else if (seen_ids[id]) first_id_err = svsf_pkg::IDERR_DUP;
               else seen_ids[id] = 1'b1;
            end
         end else begin
            overflow = 1'b1;
         end
         if (!is_last) return;

         if (overflow) st = svsf_pkg::STAT_BAD_COUNT;
         else if (target_reg == svsf_pkg::REG_INVALID) st = svsf_pkg::STAT_BAD_REG;
         else if (first_id_err == svsf_pkg::IDERR_BAD) st = svsf_pkg::STAT_BAD_ID;
         else if (first_id_err == svsf_pkg::IDERR_DUP) st = svsf_pkg::STAT_DUP_ID;
         else st = svsf_pkg::STAT_OK;

         if (st != svsf_pkg::STAT_OK) begin
            push_byte(8'h00, st, 1'b1);
            clear_set();
            return;
         end

         body.push_back(svsf_pkg::BCAST_ID);
         body.push_back(8'(svsf_pkg::LEN_BASE + 3 * entry_count));
         body.push_back(svsf_pkg::SYNC_INSTR);
         body.push_back(target_reg);
         body.push_back(svsf_pkg::WORD_LEN);
         for (int i = 0; i < entry_count; i++) begin
            body.push_back(ids[i]);
            body.push_back(positions[i][7:0]);
            body.push_back(positions[i][15:8]);
         end
         push_byte(svsf_pkg::HDR_BYTE, svsf_pkg::STAT_OK, 1'b0);
         push_byte(svsf_pkg::HDR_BYTE, svsf_pkg::STAT_OK, 1'b0);
         cksum = 8'h00;
         foreach (body[i]) begin
            cksum = cksum + body[i];
            push_byte(body[i], svsf_pkg::STAT_OK, 1'b0);
         end
         push_byte(~cksum, svsf_pkg::STAT_OK, 1'b1);
         clear_set();
      endfunction

      function void check_byte(logic [7:0] got_byte, logic [2:0] got_status, logic got_last);
         frame_byte_type e;
         if (pending_bytes.size() == 0) begin
            $error("unexpected result transaction: out_byte %h status %0d last_byte %b",
                   got_byte, got_status, got_last);
            mismatches++;
            return;
         end
         e = pending_bytes.pop_front();
         if (got_byte !== e.out_byte) begin
            $error("out_byte mismatch: expected %h, got %h", e.out_byte, got_byte);
            mismatches++;
         end
         if (got_status !== e.status) begin
            $error("status mismatch: expected %0d, got %0d", e.status, got_status);
            mismatches++;
         end
         if (got_last !== e.last_byte) begin
            $error("last_byte mismatch: expected %b, got %b", e.last_byte, got_last);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [svsf_pkg::ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   svsf_req_if req_chan ();
   svsf_rsp_if rsp_chan ();

   sync_frame_scoreboard sb;
   int items_sent;
   int burst_left;
   bit hold_request;

   servo_sync_write_packet_framer_core #(.MAX_SERVOS(MAX_ENTRIES)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_byte(rsp_chan.out_byte, rsp_chan.status, rsp_chan.last_byte);
   end

   // Receiver: changing stall patterns plus one long hold-off.
   initial begin
      int mode;
      int mode_left;
      int hold_left;
      int phase_cnt;
      bit hold_done;
      mode = 0;
      mode_left = 30;
      hold_left = 0;
      phase_cnt = 0;
      hold_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         phase_cnt++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= 1'($urandom_range(0, 1));
               2: rsp_chan.ready <= (phase_cnt % 3) != 0;
               default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic send_entry(logic [7:0] id, logic [15:0] pos, logic is_last);
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4))
            @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_chan.valid      <= 1'b1;
      req_chan.bus_id     <= id;
      req_chan.position   <= pos;
      req_chan.last_entry <= is_last;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_entry(id, pos, is_last);
      items_sent++;
   endtask

   // fault: 0 clean, 1 one invalid id, 2 one duplicate id, 3 random ids
   task automatic send_set(int n, int fault);
      logic [7:0] ids[18];
      bit used[256];
      int k;
      for (int i = 0; i < n; i++) begin
         if (fault == 3) begin
            ids[i] = 8'($urandom_range(0, 255));
         end else begin
            do ids[i] = 8'($urandom_range(1, 253)); while (used[ids[i]]);
            used[ids[i]] = 1'b1;
         end
      end
      if (fault == 1) begin
         k = $urandom_range(0, n - 1);
         case ($urandom_range(0, 2))
            0: ids[k] = 8'h00;
            1: ids[k] = svsf_pkg::BCAST_ID;
            default: ids[k] = 8'hFF;
         endcase
      end else if (fault == 2 && n >= 2) begin
         k = $urandom_range(1, n - 1);
         ids[k] = ids[$urandom_range(0, k - 1)];
      end
      for (int i = 0; i < n; i++)
         send_entry(ids[i], 16'($urandom), i == n - 1);
   endtask

   task automatic apb_write(logic [svsf_pkg::ADDR_W-1:0] addr, logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic apb_check_read(logic [svsf_pkg::ADDR_W-1:0] addr, logic [31:0] want);
      logic [31:0] got;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== want) begin
         $error("target_register readback mismatch: expected %h, got %h", want, got);
         sb.mismatches++;
      end
   endtask

   // Drain the block, then retarget the register and read it back.
   task automatic config_phase(logic [7:0] reg_value);
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (sb.pending_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      apb_write(svsf_pkg::ADDR_TARGET_REG, {24'h0, reg_value});
      sb.target_reg = reg_value;
      apb_check_read(svsf_pkg::ADDR_TARGET_REG, {24'h0, reg_value});
   endtask

   initial begin
      int rand_base;
      int n;
      int r;
      logic [7:0] reg_value;
      sb = new();
      items_sent = 0;
      burst_left = 0;
      hold_request = 1'b0;
      reset               <= 1'b1;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.bus_id     <= '0;
      req_chan.position   <= '0;
      req_chan.last_entry <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      apb_check_read(svsf_pkg::ADDR_TARGET_REG, {24'h0, svsf_pkg::REG_RESET});

      // single-entry frames at the field extremes, then each id fault
      send_entry(8'h01, 16'h0000, 1'b1);
      send_entry(8'hFD, 16'hFFFF, 1'b1);
      send_entry(8'h00, 16'h1234, 1'b1);
      send_entry(svsf_pkg::BCAST_ID, 16'h00FF, 1'b1);
      send_entry(8'hFF, 16'hFF00, 1'b1);
      send_entry(8'h55, 16'hAAAA, 1'b0);
      send_entry(8'h55, 16'h5555, 1'b1);
      // duplicate seen before a later invalid id
      send_entry(8'h10, 16'h0102, 1'b0);
      send_entry(8'h10, 16'h0304, 1'b0);
      send_entry(8'h00, 16'h0506, 1'b1);
      // invalid id seen before a later duplicate
      send_entry(8'h00, 16'h0708, 1'b0);
      send_entry(8'h20, 16'h090A, 1'b0);
      send_entry(8'h20, 16'h0B0C, 1'b1);

      // register 255 wins over id faults
      config_phase(svsf_pkg::REG_INVALID);
      send_entry(8'h33, 16'h8000, 1'b1);
      send_entry(8'h00, 16'h0001, 1'b1);

      config_phase(8'h00);
      send_entry(8'h80, 16'h8001, 1'b0);
      send_entry(8'h7F, 16'h7FFE, 1'b1);

      rand_base = items_sent;
      config_phase(svsf_pkg::REG_RESET);
      hold_request = 1'b1;
      send_set(MAX_ENTRIES, 0);
      send_set(MAX_ENTRIES + 1, 0);
      config_phase(svsf_pkg::REG_INVALID);
      send_set(MAX_ENTRIES + 2, 0);
      config_phase(8'($urandom_range(1, 254)));

      while (items_sent - rand_base < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 5))
               0: reg_value = 8'h00;
               1: reg_value = svsf_pkg::REG_INVALID;
               2: reg_value = svsf_pkg::REG_RESET;
               default: reg_value = 8'($urandom_range(0, 254));
            endcase
            config_phase(reg_value);
         end
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, MAX_ENTRIES + 2)
                                         : $urandom_range(1, 5);
         r = $urandom_range(0, 9);
         send_set(n, (r < 7) ? 0 : (r == 7) ? 1 : (r == 8) ? 2 : 3);
      end

      req_chan.valid <= 1'b0;
      while (sb.pending_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
